// ===== sv/bcs_pkg.sv =====
// ----------------------------------------------------------------------------
// bcs_pkg: shared types and constants of the battery charge scheduler
// Battery codes, mode codes, configuration layout and the back-off function.
// ----------------------------------------------------------------------------
package bcs_pkg;

	localparam logic [15:0] LF_SANITY_MV      = 16'd3300;
	localparam logic [15:0] PANEL_SUN_REF     = 16'd2048;
	localparam logic [31:0] RECOMMISSION_STEP = 32'd3600;
	localparam logic [31:0] RECOMMISSION_MAX  = 32'd86400;

	// battery / charge choice codes
	localparam logic [2:0] BAT_LI1  = 3'd0;
	localparam logic [2:0] BAT_LI2  = 3'd1;
	localparam logic [2:0] BAT_LF1  = 3'd2;
	localparam logic [2:0] BAT_LF2  = 3'd3;
	localparam logic [2:0] BAT_NONE = 3'd4;

	// discharge choice codes
	localparam logic [1:0] DIS_LI1  = 2'd0;
	localparam logic [1:0] DIS_LI2  = 2'd1;
	localparam logic [1:0] DIS_BOTH = 2'd2;

	// meta state codes
	localparam logic [1:0] META_GOOD   = 2'd0;
	localparam logic [1:0] META_ONE_LI = 2'd1;
	localparam logic [1:0] META_TWO_LF = 2'd2;
	localparam logic [1:0] META_TWO_LI = 2'd3;

	// charge substate codes
	localparam logic [2:0] SUB_NONE_FULL = 3'd0;
	localparam logic [2:0] SUB_LI1_FULL  = 3'd1;
	localparam logic [2:0] SUB_LI2_FULL  = 3'd2;
	localparam logic [2:0] SUB_FILL_LF   = 3'd3;
	localparam logic [2:0] SUB_B_FILL_LI = 3'd4;
	localparam logic [2:0] SUB_B_FILL_LF = 3'd5;
	localparam logic [2:0] SUB_C         = 3'd6;
	localparam logic [2:0] SUB_D         = 3'd7;

	// register indexes
	localparam logic [2:0] REG_LI_FULL_SANITY = 3'd0;
	localparam logic [2:0] REG_LI_FULL        = 3'd1;
	localparam logic [2:0] REG_LF_FULL_MAX    = 3'd2;
	localparam logic [2:0] REG_LI_DOWN        = 3'd3;
	localparam logic [2:0] REG_LI_LOW_POWER   = 3'd4;
	localparam logic [2:0] REG_LI_CRITICAL    = 3'd5;
	localparam logic [2:0] REG_MAX_NO_FULL    = 3'd6;
	localparam logic [2:0] REG_MAX_LOW_VOLT   = 3'd7;

	typedef struct packed {
		logic [15:0] li_sane_thr;
		logic [15:0] li_full_thr;
		logic [15:0] lf_full_thr;
		logic [15:0] li_down_thr;
		logic [15:0] li_low_thr;
		logic [15:0] li_crit_thr;
		logic [31:0] max_time_without_full;
		logic [31:0] max_time_low_voltage;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now;
		logic [15:0] li1_mv;
		logic [15:0] li2_mv;
		logic [15:0] lf_cell1_mv;
		logic [15:0] lf_cell2_mv;
		logic [15:0] lf_cell3_mv;
		logic [15:0] lf_cell4_mv;
		logic        sat_idle;
		logic        charger_running;
		logic [15:0] panel_ref;
		logic [3:0]  fault_mask;
	} item_t;

	// Recommission back-off grows with the retire count up to a ceiling.
	function automatic logic [31:0] backoff(input logic [7:0] cnt);
		logic [31:0] prod;
		begin
			prod = 32'(cnt) * RECOMMISSION_STEP;
			backoff = (prod > RECOMMISSION_MAX) ? RECOMMISSION_MAX : prod;
		end
	endfunction

endpackage

// ===== sv/battery_charge_scheduler_top.sv =====
// The result beat is presented after its input beat passes the input register
// and then the result register, or later while the result register is stalled.
// Throughput: one tick per cycle while the receiver does not stall; the whole
// update is one pass between the input register and the result register.
// Reset: arst_n clears the scheduler state, the valid flags and restores the
// register defaults at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// battery_charge_scheduler_top: periodic battery charge scheduler
// Input register, handshake control, configuration port and scheduler core.
// ----------------------------------------------------------------------------
module battery_charge_scheduler_top import bcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now,
	input  logic [15:0] li1_mv,
	input  logic [15:0] li2_mv,
	input  logic [15:0] lf_cell1_mv,
	input  logic [15:0] lf_cell2_mv,
	input  logic [15:0] lf_cell3_mv,
	input  logic [15:0] lf_cell4_mv,
	input  logic        sat_idle,
	input  logic        charger_running,
	input  logic [15:0] panel_ref,
	input  logic [3:0]  fault_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  charge_select,
	output logic [1:0]  discharge_select,
	output logic [1:0]  meta_state,
	output logic [2:0]  charge_state,
	output logic        antenna_deploy_ok,
	output logic [3:0]  above_sanity_mask,
	output logic [3:0]  decommissioned_mask,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	logic  advance;
	logic  in_take;

	// The held item moves on whenever the result register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.now             <= now;
			item_s1.li1_mv          <= li1_mv;
			item_s1.li2_mv          <= li2_mv;
			item_s1.lf_cell1_mv     <= lf_cell1_mv;
			item_s1.lf_cell2_mv     <= lf_cell2_mv;
			item_s1.lf_cell3_mv     <= lf_cell3_mv;
			item_s1.lf_cell4_mv     <= lf_cell4_mv;
			item_s1.sat_idle        <= sat_idle;
			item_s1.charger_running <= charger_running;
			item_s1.panel_ref       <= panel_ref;
			item_s1.fault_mask      <= fault_mask;
		end
	end

	bcs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcs_core u_core (
		.clk                 (clk),
		.arst_n              (arst_n),
		.advance             (advance),
		.item_s1             (item_s1),
		.cfg                 (cfg),
		.charge_select       (charge_select),
		.discharge_select    (discharge_select),
		.meta_state          (meta_state),
		.charge_state        (charge_state),
		.antenna_deploy_ok   (antenna_deploy_ok),
		.above_sanity_mask   (above_sanity_mask),
		.decommissioned_mask (decommissioned_mask)
	);

endmodule

// ===== sv/bcs_cfg.sv =====
// ----------------------------------------------------------------------------
// bcs_cfg: configuration register file
// APB-style write and read access to the eight threshold and timeout registers.
// ----------------------------------------------------------------------------
module bcs_cfg import bcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.li_sane_thr           <= 16'd4000;
			cfg_q.li_full_thr           <= 16'd4100;
			cfg_q.lf_full_thr           <= 16'd3600;
			cfg_q.li_down_thr           <= 16'd3800;
			cfg_q.li_low_thr            <= 16'd3600;
			cfg_q.li_crit_thr           <= 16'd3000;
			cfg_q.max_time_without_full <= 32'd86400;
			cfg_q.max_time_low_voltage  <= 32'd3600;
		end else if (wr_en) begin
			unique case (idx)
				REG_LI_FULL_SANITY: cfg_q.li_sane_thr           <= pwdata[15:0];
				REG_LI_FULL:        cfg_q.li_full_thr           <= pwdata[15:0];
				REG_LF_FULL_MAX:    cfg_q.lf_full_thr           <= pwdata[15:0];
				REG_LI_DOWN:        cfg_q.li_down_thr           <= pwdata[15:0];
				REG_LI_LOW_POWER:   cfg_q.li_low_thr            <= pwdata[15:0];
				REG_LI_CRITICAL:    cfg_q.li_crit_thr           <= pwdata[15:0];
				REG_MAX_NO_FULL:    cfg_q.max_time_without_full <= pwdata;
				REG_MAX_LOW_VOLT:   cfg_q.max_time_low_voltage  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LI_FULL_SANITY: prdata = {16'd0, cfg_q.li_sane_thr};
			REG_LI_FULL:        prdata = {16'd0, cfg_q.li_full_thr};
			REG_LF_FULL_MAX:    prdata = {16'd0, cfg_q.lf_full_thr};
			REG_LI_DOWN:        prdata = {16'd0, cfg_q.li_down_thr};
			REG_LI_LOW_POWER:   prdata = {16'd0, cfg_q.li_low_thr};
			REG_LI_CRITICAL:    prdata = {16'd0, cfg_q.li_crit_thr};
			REG_MAX_NO_FULL:    prdata = cfg_q.max_time_without_full;
			REG_MAX_LOW_VOLT:   prdata = cfg_q.max_time_low_voltage;
			default:            prdata = 32'd0;
		endcase
	end

endmodule

// ===== sv/bcs_core.sv =====
// ----------------------------------------------------------------------------
// bcs_core: scheduler state and single-pass update
// Holds the per-battery state, computes one tick's update from the registered
// item and loads the result registers.
// ----------------------------------------------------------------------------
module bcs_core import bcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  item_t       item_s1,
	input  cfg_t        cfg,
	output logic [2:0]  charge_select,
	output logic [1:0]  discharge_select,
	output logic [1:0]  meta_state,
	output logic [2:0]  charge_state,
	output logic        antenna_deploy_ok,
	output logic [3:0]  above_sanity_mask,
	output logic [3:0]  decommissioned_mask
);

	// state
	logic [2:0]  chg_q;
	logic [1:0]  dis_q;
	logic [1:0]  meta_q;
	logic [2:0]  sub_q;
	logic [31:0] lft_q [2];
	logic [31:0] lvs_q [2];
	logic [1:0]  lvv_q;
	logic [3:0]  ret_q;
	logic [31:0] rt_q  [4];
	logic [7:0]  cnt_q [4];
	logic        parity_q;
	logic        deploy_q;

	// next state
	logic [2:0]  chg_n;
	logic [1:0]  dis_n;
	logic [1:0]  meta_n;
	logic [2:0]  sub_n;
	logic [31:0] lft_n [2];
	logic [31:0] lvs_n [2];
	logic [1:0]  lvv_n;
	logic [3:0]  ret_n;
	logic [31:0] rt_n  [4];
	logic [7:0]  cnt_n [4];
	logic        parity_n;
	logic        deploy_n;

	logic [15:0] v [4];
	logic [31:0] now;
	logic        filled;
	logic [15:0] cv;
	logic [1:0]  nli;
	logic [1:0]  nlf;
	logic        good_li;
	logic [1:0]  good_lf;
	logic [2:0]  lower_lf;
	logic        lf_full;
	logic [3:0]  mask;
	logic [1:0]  new_meta;

	assign now  = item_s1.now;
	assign v[0] = item_s1.li1_mv;
	assign v[1] = item_s1.li2_mv;
	assign v[2] = (item_s1.lf_cell1_mv > item_s1.lf_cell2_mv) ?
		item_s1.lf_cell1_mv : item_s1.lf_cell2_mv;
	assign v[3] = (item_s1.lf_cell3_mv > item_s1.lf_cell4_mv) ?
		item_s1.lf_cell3_mv : item_s1.lf_cell4_mv;

	always_comb begin
		chg_n    = chg_q;
		dis_n    = dis_q;
		meta_n   = meta_q;
		sub_n    = sub_q;
		lft_n    = lft_q;
		lvs_n    = lvs_q;
		lvv_n    = lvv_q;
		ret_n    = ret_q;
		rt_n     = rt_q;
		cnt_n    = cnt_q;
		parity_n = parity_q;
		deploy_n = deploy_q;

		// Did the Li-ion being charged fill up?
		cv     = v[{1'b0, chg_q[0]}];
		filled = 1'b0;
		if (chg_q < BAT_LF1) begin
			filled = (!item_s1.charger_running && cv > cfg.li_sane_thr &&
				item_s1.panel_ref >= PANEL_SUN_REF) || cv > cfg.li_full_thr;
			if (filled)
				lft_n[chg_q[0]] = now;
		end

		// Recommission after the back-off.
		for (int b = 0; b < 4; b++) begin
			if (ret_q[b] && (now - rt_q[b]) > backoff(cnt_q[b])) begin
				ret_n[b] = 1'b0;
				if (b < 2) begin
					lvv_n[b] = 1'b0;
					lft_n[b] = now;
				end
			end
		end

		// Li-ion timeouts.
		for (int b = 0; b < 2; b++) begin
			if (!ret_n[b]) begin
				if ((now - lft_n[b]) > cfg.max_time_without_full) begin
					ret_n[b] = 1'b1;
					rt_n[b]  = now;
					if (cnt_n[b] != 8'hFF)
						cnt_n[b] = cnt_n[b] + 8'd1;
				end else if (v[b] <= cfg.li_crit_thr) begin
					if (!lvv_n[b]) begin
						lvv_n[b] = 1'b1;
						lvs_n[b] = now;
					end else if ((now - lvs_n[b]) > cfg.max_time_low_voltage) begin
						ret_n[b] = 1'b1;
						rt_n[b]  = now;
						if (cnt_n[b] != 8'hFF)
							cnt_n[b] = cnt_n[b] + 8'd1;
					end
				end else begin
					lvv_n[b] = 1'b0;
				end
			end
		end

		nli     = {1'b0, ret_n[0]} + {1'b0, ret_n[1]};
		nlf     = {1'b0, ret_n[2]} + {1'b0, ret_n[3]};
		good_li = (nli == 2'd1) ? ret_n[0] : 1'b0;
		good_lf = (nlf == 2'd1 && ret_n[2]) ? BAT_LF2[1:0] : BAT_LF1[1:0];
		if (nlf == 2'd1)
			lower_lf = {1'b0, good_lf};
		else
			lower_lf = (v[2] <= v[3]) ? BAT_LF1 : BAT_LF2;

		lf_full = (nlf == 2'd0 && v[2] > cfg.lf_full_thr && v[3] > cfg.lf_full_thr)
			|| (nlf == 2'd1 && v[good_lf] > cfg.lf_full_thr);

		if (nli == 2'd0) begin
			if (v[0] > cfg.li_sane_thr && v[1] > cfg.li_sane_thr)
				deploy_n = 1'b1;
		end else if (nli == 2'd1) begin
			if (v[{1'b0, good_li}] > cfg.li_sane_thr)
				deploy_n = 1'b1;
		end else begin
			deploy_n = 1'b1;
		end

		mask[0] = v[0] > cfg.li_sane_thr;
		mask[1] = v[1] > cfg.li_sane_thr;
		mask[2] = v[2] > LF_SANITY_MV;
		mask[3] = v[3] > LF_SANITY_MV;

		if (nli == 2'd0)
			new_meta = (nlf < 2'd2) ? META_GOOD : META_TWO_LF;
		else if (nli == 2'd1)
			new_meta = (nlf < 2'd2) ? META_ONE_LI : META_TWO_LF;
		else
			new_meta = META_TWO_LI;

		// Substate transitions.
		if (new_meta != meta_q) begin
			meta_n = new_meta;
			case (new_meta)
				META_GOOD:   sub_n = SUB_NONE_FULL;
				META_ONE_LI: sub_n = SUB_B_FILL_LI;
				META_TWO_LF: sub_n = SUB_C;
				default:     sub_n = SUB_D;
			endcase
		end else if (meta_q == META_GOOD) begin
			if (!item_s1.sat_idle || lf_full)
				sub_n = SUB_NONE_FULL;
			else begin
				case (sub_q)
					SUB_NONE_FULL: begin
						if (chg_q == BAT_LI1 && filled)
							sub_n = SUB_LI1_FULL;
						else if (chg_q == BAT_LI2 && filled)
							sub_n = SUB_LI2_FULL;
					end
					SUB_LI1_FULL: begin
						if (v[0] <= cfg.li_sane_thr || v[1] <= cfg.li_low_thr)
							sub_n = SUB_NONE_FULL;
						else if (chg_q == BAT_LI2 && filled)
							sub_n = SUB_FILL_LF;
					end
					SUB_LI2_FULL: begin
						if (v[1] <= cfg.li_sane_thr || v[0] <= cfg.li_low_thr)
							sub_n = SUB_NONE_FULL;
						else if (chg_q == BAT_LI1 && filled)
							sub_n = SUB_FILL_LF;
					end
					SUB_FILL_LF: begin
						if (v[0] <= cfg.li_down_thr || v[1] <= cfg.li_down_thr)
							sub_n = SUB_NONE_FULL;
					end
					default: ;
				endcase
			end
		end else if (meta_q == META_ONE_LI) begin
			if (!item_s1.sat_idle || lf_full)
				sub_n = SUB_B_FILL_LI;
			else if (sub_q == SUB_B_FILL_LI) begin
				if (chg_q == {2'b00, good_li} && filled)
					sub_n = SUB_B_FILL_LF;
			end else if (sub_q == SUB_B_FILL_LF) begin
				if (v[{1'b0, good_li}] <= cfg.li_down_thr)
					sub_n = SUB_B_FILL_LI;
			end
		end

		// Choices.
		case (meta_n)
			META_GOOD: begin
				case (sub_n)
					SUB_NONE_FULL: begin
						if (v[0] <= v[1]) begin
							chg_n = BAT_LI1;
							dis_n = DIS_LI2;
						end else begin
							chg_n = BAT_LI2;
							dis_n = DIS_LI1;
						end
					end
					SUB_LI1_FULL: begin
						chg_n = BAT_LI2;
						dis_n = DIS_LI1;
					end
					SUB_LI2_FULL: begin
						chg_n = BAT_LI1;
						dis_n = DIS_LI2;
					end
					SUB_FILL_LF: begin
						chg_n = lower_lf;
						dis_n = (v[0] <= v[1]) ? DIS_LI2 : DIS_LI1;
					end
					default: ;
				endcase
			end
			META_ONE_LI: begin
				if (sub_n == SUB_B_FILL_LI) begin
					chg_n = {2'b00, good_li};
					dis_n = {1'b0, good_li};
				end else if (sub_n == SUB_B_FILL_LF) begin
					chg_n = lower_lf;
					dis_n = {1'b0, good_li};
				end
			end
			META_TWO_LF: begin
				if (nli == 2'd0) begin
					if (v[0] <= v[1]) begin
						chg_n = BAT_LI1;
						dis_n = DIS_LI2;
					end else begin
						chg_n = BAT_LI2;
						dis_n = DIS_LI1;
					end
				end else begin
					chg_n = {2'b00, good_li};
					dis_n = {1'b0, good_li};
				end
			end
			default: begin
				chg_n    = parity_q ? BAT_LI1 : BAT_LI2;
				dis_n    = DIS_BOTH;
				parity_n = !parity_q;
			end
		endcase

		// Charger faults retire at the end of the tick.
		for (int b = 0; b < 4; b++) begin
			if (item_s1.fault_mask[b] && !ret_n[b]) begin
				ret_n[b] = 1'b1;
				rt_n[b]  = now;
				if (cnt_n[b] != 8'hFF)
					cnt_n[b] = cnt_n[b] + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chg_q    <= BAT_NONE;
			dis_q    <= DIS_BOTH;
			meta_q   <= META_GOOD;
			sub_q    <= SUB_NONE_FULL;
			lvv_q    <= 2'b00;
			ret_q    <= 4'b0000;
			parity_q <= 1'b0;
			deploy_q <= 1'b0;
			for (int b = 0; b < 2; b++) begin
				lft_q[b] <= 32'd0;
				lvs_q[b] <= 32'd0;
			end
			for (int b = 0; b < 4; b++) begin
				rt_q[b]  <= 32'd0;
				cnt_q[b] <= 8'd0;
			end
		end else if (advance) begin
			chg_q    <= chg_n;
			dis_q    <= dis_n;
			meta_q   <= meta_n;
			sub_q    <= sub_n;
			lft_q    <= lft_n;
			lvs_q    <= lvs_n;
			lvv_q    <= lvv_n;
			ret_q    <= ret_n;
			rt_q     <= rt_n;
			cnt_q    <= cnt_n;
			parity_q <= parity_n;
			deploy_q <= deploy_n;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (advance) begin
			charge_select       <= chg_n;
			discharge_select    <= dis_n;
			meta_state          <= meta_n;
			charge_state        <= sub_n;
			antenna_deploy_ok   <= deploy_n;
			above_sanity_mask   <= mask;
			decommissioned_mask <= ret_n;
		end
	end

endmodule

// ===== sv/bcs_checker.sv =====
// ----------------------------------------------------------------------------
// bcs_checker: port-level checks of the scheduler
// Result code ranges, mode consistency, the sticky deploy flag and stalled beat hold.
// ----------------------------------------------------------------------------
module bcs_checker import bcs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] charge_select,
	input logic [1:0] discharge_select,
	input logic [1:0] meta_state,
	input logic [2:0] charge_state,
	input logic       antenna_deploy_ok
);

	// With both Li-ion cells down, both discharge and one of them charges.
	a_two_li_down: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && meta_state == META_TWO_LI |->
			discharge_select == DIS_BOTH && charge_state == SUB_D &&
			(charge_select == BAT_LI1 || charge_select == BAT_LI2))
		else $error("two-Li-ion-down beat with inconsistent choices");

	// In the all-good state the substate is one of the four type A substates.
	a_sub_in_meta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && meta_state == META_GOOD |-> charge_state <= SUB_FILL_LF)
		else $error("substate does not belong to the all-good state");

	// After the first tick a battery is always chosen.
	a_choice_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> charge_select <= BAT_LF2 && discharge_select != 2'd3)
		else $error("charge or discharge choice out of range");

	// Once granted, the deploy flag never drops.
	a_deploy_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && antenna_deploy_ok |=> antenna_deploy_ok)
		else $error("antenna deploy flag fell");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(charge_select))
		else $error("stalled result beat changed");

endmodule

bind battery_charge_scheduler_top bcs_checker u_bcs_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.charge_select     (charge_select),
	.discharge_select  (discharge_select),
	.meta_state        (meta_state),
	.charge_state      (charge_state),
	.antenna_deploy_ok (antenna_deploy_ok)
);

// ===== bench/battery_charge_scheduler_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_scheduler_top_test: self-checking bench for the scheduler
// Drives ticks through the valid/stall handshake with a bursty sender and a
// stalling receiver, predicts every result beat and compares field by field.
// ----------------------------------------------------------------------------
module battery_charge_scheduler_top_test;
	import bcs_pkg::*;

	localparam int NUM_RANDOM = 1450;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [2:0] chg;
		logic [1:0] dis;
		logic [1:0] meta;
		logic [2:0] sub;
		logic       deploy;
		logic [3:0] sane;
		logic [3:0] retired;
	} verdict_t;

	typedef struct {
		item_t    tick;
		bit       has_fixed;
		verdict_t fixed;
	} tick_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	item_t       cur_tick = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  charge_select;
	logic [1:0]  discharge_select;
	logic [1:0]  meta_state;
	logic [2:0]  charge_state;
	logic        antenna_deploy_ok;
	logic [3:0]  above_sanity_mask;
	logic [3:0]  decommissioned_mask;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	battery_charge_scheduler_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.now(cur_tick.now), .li1_mv(cur_tick.li1_mv), .li2_mv(cur_tick.li2_mv),
		.lf_cell1_mv(cur_tick.lf_cell1_mv), .lf_cell2_mv(cur_tick.lf_cell2_mv),
		.lf_cell3_mv(cur_tick.lf_cell3_mv), .lf_cell4_mv(cur_tick.lf_cell4_mv),
		.sat_idle(cur_tick.sat_idle), .charger_running(cur_tick.charger_running),
		.panel_ref(cur_tick.panel_ref), .fault_mask(cur_tick.fault_mask),
		.out_valid(out_valid), .out_stall(out_stall),
		.charge_select(charge_select), .discharge_select(discharge_select),
		.meta_state(meta_state), .charge_state(charge_state),
		.antenna_deploy_ok(antenna_deploy_ok), .above_sanity_mask(above_sanity_mask),
		.decommissioned_mask(decommissioned_mask),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state and its copy of the registers.
	cfg_t        thr;
	logic [2:0]  p_chg;
	logic [1:0]  p_dis;
	logic [1:0]  p_meta;
	logic [2:0]  p_sub;
	logic [31:0] p_full_at [2];
	logic [31:0] p_low_at [2];
	bit          p_low_on [2];
	bit          p_out [4];
	logic [31:0] p_out_at [4];
	logic [7:0]  p_out_cnt [4];
	bit          p_parity;
	bit          p_deploy;

	verdict_t    pending_verdicts [$];
	verdict_t    pending_fixed [$];
	bit          pending_has_fixed [$];
	int          failures = 0;
	int          idle_cycles = 0;
	logic [31:0] clock_now = 32'd0;

	function automatic logic [31:0] hold_off(int b);
		logic [63:0] t;
		t = 64'(p_out_cnt[b]) * 64'(RECOMMISSION_STEP);
		return (t > 64'(RECOMMISSION_MAX)) ? RECOMMISSION_MAX : t[31:0];
	endfunction

	function automatic void retire_bat(int b, logic [31:0] t);
		if (!p_out[b]) begin
			p_out[b] = 1'b1;
			p_out_at[b] = t;
			if (p_out_cnt[b] != 8'd255)
				p_out_cnt[b]++;
		end
	endfunction

	function automatic void reset_predictor();
		thr = '{16'd4000, 16'd4100, 16'd3600, 16'd3800, 16'd3600, 16'd3000,
			32'd86400, 32'd3600};
		p_chg = BAT_NONE;
		p_dis = DIS_BOTH;
		p_meta = META_GOOD;
		p_sub = SUB_NONE_FULL;
		for (int b = 0; b < 4; b++) begin
			p_out[b] = 1'b0;
			p_out_at[b] = '0;
			p_out_cnt[b] = '0;
		end
		for (int b = 0; b < 2; b++) begin
			p_full_at[b] = '0;
			p_low_at[b] = '0;
			p_low_on[b] = 1'b0;
		end
		p_parity = 1'b0;
		p_deploy = 1'b0;
	endfunction

	function automatic logic [2:0] lower_bank(int nlf, logic [2:0] good_lf,
			logic [15:0] v [4]);
		if (nlf == 1)
			return good_lf;
		return (v[2] <= v[3]) ? BAT_LF1 : BAT_LF2;
	endfunction

	function automatic verdict_t schedule_tick(item_t t);
		logic [15:0] v [4];
		bit          filled;
		int          nli, nlf;
		logic [2:0]  good_li, good_lf;
		logic [1:0]  new_meta;
		bit          lf_full;
		verdict_t    r;
		v[0] = t.li1_mv;
		v[1] = t.li2_mv;
		v[2] = (t.lf_cell1_mv > t.lf_cell2_mv) ? t.lf_cell1_mv : t.lf_cell2_mv;
		v[3] = (t.lf_cell3_mv > t.lf_cell4_mv) ? t.lf_cell3_mv : t.lf_cell4_mv;
		filled = 1'b0;
		good_li = BAT_LI1;
		good_lf = BAT_LF1;
		r = '0;
		if (p_chg < BAT_LF1) begin
			filled = (!t.charger_running && v[p_chg[1:0]] > thr.li_sane_thr
				&& t.panel_ref >= PANEL_SUN_REF) || v[p_chg[1:0]] > thr.li_full_thr;
			if (filled)
				p_full_at[p_chg[0]] = t.now;
		end
		for (int b = 0; b < 4; b++) begin
			if (p_out[b] && (t.now - p_out_at[b]) > hold_off(b)) begin
				p_out[b] = 1'b0;
				if (b < 2) begin
					p_low_on[b] = 1'b0;
					p_full_at[b] = t.now;
				end
			end
		end
		for (int b = 0; b < 2; b++) begin
			if (!p_out[b]) begin
				if ((t.now - p_full_at[b]) > thr.max_time_without_full)
					retire_bat(b, t.now);
				else if (v[b] <= thr.li_crit_thr) begin
					if (!p_low_on[b]) begin
						p_low_on[b] = 1'b1;
						p_low_at[b] = t.now;
					end else if ((t.now - p_low_at[b]) > thr.max_time_low_voltage)
						retire_bat(b, t.now);
				end else
					p_low_on[b] = 1'b0;
			end
		end
		nli = int'(p_out[0]) + int'(p_out[1]);
		nlf = int'(p_out[2]) + int'(p_out[3]);
		if (nli == 1)
			good_li = p_out[0] ? BAT_LI2 : BAT_LI1;
		if (nlf == 1)
			good_lf = p_out[2] ? BAT_LF2 : BAT_LF1;
		lf_full = (nlf == 0 && v[2] > thr.lf_full_thr && v[3] > thr.lf_full_thr)
			|| (nlf == 1 && v[good_lf[1:0]] > thr.lf_full_thr);
		if (nli == 0) begin
			if (v[0] > thr.li_sane_thr && v[1] > thr.li_sane_thr)
				p_deploy = 1'b1;
		end else if (nli == 1) begin
			if (v[good_li[1:0]] > thr.li_sane_thr)
				p_deploy = 1'b1;
		end else
			p_deploy = 1'b1;
		for (int b = 0; b < 4; b++)
			r.sane[b] = v[b] > ((b < 2) ? thr.li_sane_thr : LF_SANITY_MV);
		if (nli == 0)
			new_meta = (nlf < 2) ? META_GOOD : META_TWO_LF;
		else if (nli == 1)
			new_meta = (nlf < 2) ? META_ONE_LI : META_TWO_LF;
		else
			new_meta = META_TWO_LI;
		if (new_meta != p_meta) begin
			p_meta = new_meta;
			case (p_meta)
				META_GOOD: p_sub = SUB_NONE_FULL;
				META_ONE_LI: p_sub = SUB_B_FILL_LI;
				META_TWO_LF: p_sub = SUB_C;
				default: p_sub = SUB_D;
			endcase
		end else if (p_meta == META_GOOD) begin
			if (!t.sat_idle || lf_full)
				p_sub = SUB_NONE_FULL;
			else if (p_sub == SUB_NONE_FULL) begin
				if (p_chg == BAT_LI1 && filled)
					p_sub = SUB_LI1_FULL;
				else if (p_chg == BAT_LI2 && filled)
					p_sub = SUB_LI2_FULL;
			end else if (p_sub == SUB_LI1_FULL) begin
				if (v[0] <= thr.li_sane_thr || v[1] <= thr.li_low_thr)
					p_sub = SUB_NONE_FULL;
				else if (p_chg == BAT_LI2 && filled)
					p_sub = SUB_FILL_LF;
			end else if (p_sub == SUB_LI2_FULL) begin
				if (v[1] <= thr.li_sane_thr || v[0] <= thr.li_low_thr)
					p_sub = SUB_NONE_FULL;
				else if (p_chg == BAT_LI1 && filled)
					p_sub = SUB_FILL_LF;
			end else if (p_sub == SUB_FILL_LF) begin
				if (v[0] <= thr.li_down_thr || v[1] <= thr.li_down_thr)
					p_sub = SUB_NONE_FULL;
			end
		end else if (p_meta == META_ONE_LI) begin
			if (!t.sat_idle || lf_full)
				p_sub = SUB_B_FILL_LI;
			else if (p_sub == SUB_B_FILL_LI) begin
				if (p_chg == good_li && filled)
					p_sub = SUB_B_FILL_LF;
			end else if (p_sub == SUB_B_FILL_LF) begin
				if (v[good_li[1:0]] <= thr.li_down_thr)
					p_sub = SUB_B_FILL_LI;
			end
		end
		if (p_meta == META_GOOD) begin
			case (p_sub)
				SUB_NONE_FULL: begin
					p_chg = (v[0] <= v[1]) ? BAT_LI1 : BAT_LI2;
					p_dis = (v[0] <= v[1]) ? DIS_LI2 : DIS_LI1;
				end
				SUB_LI1_FULL: begin
					p_chg = BAT_LI2;
					p_dis = DIS_LI1;
				end
				SUB_LI2_FULL: begin
					p_chg = BAT_LI1;
					p_dis = DIS_LI2;
				end
				SUB_FILL_LF: begin
					p_chg = lower_bank(nlf, good_lf, v);
					p_dis = (v[0] <= v[1]) ? DIS_LI2 : DIS_LI1;
				end
				default: ;
			endcase
		end else if (p_meta == META_ONE_LI) begin
			if (p_sub == SUB_B_FILL_LI) begin
				p_chg = good_li;
				p_dis = good_li[1:0];
			end else if (p_sub == SUB_B_FILL_LF) begin
				p_chg = lower_bank(nlf, good_lf, v);
				p_dis = good_li[1:0];
			end
		end else if (p_meta == META_TWO_LF) begin
			if (nli == 0) begin
				p_chg = (v[0] <= v[1]) ? BAT_LI1 : BAT_LI2;
				p_dis = (v[0] <= v[1]) ? DIS_LI2 : DIS_LI1;
			end else begin
				p_chg = good_li;
				p_dis = good_li[1:0];
			end
		end else begin
			p_chg = p_parity ? BAT_LI1 : BAT_LI2;
			p_dis = DIS_BOTH;
			p_parity = !p_parity;
		end
		// Charger faults take effect after this tick's choices are made.
		for (int b = 0; b < 4; b++)
			if (t.fault_mask[b])
				retire_bat(b, t.now);
		for (int b = 0; b < 4; b++)
			r.retired[b] = p_out[b];
		r.chg = p_chg;
		r.dis = p_dis;
		r.meta = p_meta;
		r.sub = p_sub;
		r.deploy = p_deploy;
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LI_FULL_SANITY: thr.li_sane_thr = value[15:0];
			REG_LI_FULL: thr.li_full_thr = value[15:0];
			REG_LF_FULL_MAX: thr.lf_full_thr = value[15:0];
			REG_LI_DOWN: thr.li_down_thr = value[15:0];
			REG_LI_LOW_POWER: thr.li_low_thr = value[15:0];
			REG_LI_CRITICAL: thr.li_crit_thr = value[15:0];
			REG_MAX_NO_FULL: thr.max_time_without_full = value;
			default: thr.max_time_low_voltage = value;
		endcase
	endtask

	task automatic drain();
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Sends one beat; the sender sometimes drops valid for a random gap first.
	task automatic send_tick(item_t t, bit has_fixed, verdict_t fixed);
		if ($urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cur_tick <= t;
		do @(posedge clk); while (in_stall);
		pending_verdicts.push_back(schedule_tick(t));
		pending_fixed.push_back(fixed);
		pending_has_fixed.push_back(has_fixed);
	endtask

	function automatic item_t random_tick(int mode);
		item_t t;
		t = '0;
		clock_now += (mode == 0) ? $urandom() : $urandom_range(1, 3000);
		t.now = clock_now;
		if (mode == 0) begin
			t.li1_mv = 16'($urandom());
			t.li2_mv = 16'($urandom());
			t.lf_cell1_mv = 16'($urandom());
			t.lf_cell2_mv = 16'($urandom());
			t.lf_cell3_mv = 16'($urandom());
			t.lf_cell4_mv = 16'($urandom());
			t.panel_ref = 16'($urandom());
			t.fault_mask = 4'($urandom());
		end else begin
			t.li1_mv = 16'($urandom_range(2800, 4300));
			t.li2_mv = 16'($urandom_range(2800, 4300));
			t.lf_cell1_mv = 16'($urandom_range(3000, 3800));
			t.lf_cell2_mv = 16'($urandom_range(3000, 3800));
			t.lf_cell3_mv = 16'($urandom_range(3000, 3800));
			t.lf_cell4_mv = 16'($urandom_range(3000, 3800));
			t.panel_ref = 16'($urandom_range(1500, 2600));
			t.fault_mask = ($urandom_range(0, 40) == 0) ? 4'($urandom()) : 4'd0;
		end
		t.sat_idle = ($urandom_range(0, 4) != 0);
		t.charger_running = 1'($urandom());
		return t;
	endfunction

	// Receiver stall pattern: out_stall is drawn anew on each clock, high with a chance of one in six.
	always @(posedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(0, 255) < 128) ? ($urandom_range(0, 2) == 0) : 1'b0;
	end

	always @(posedge clk) begin
		verdict_t got, want;
		bit       has_fixed;
		verdict_t fixed;
		if (arst_n && out_valid && !out_stall) begin
			got = '{charge_select, discharge_select, meta_state, charge_state,
				antenna_deploy_ok, above_sanity_mask, decommissioned_mask};
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result beat with nothing expected, got %h", $time, got);
				failures++;
			end else begin
				want = pending_verdicts.pop_front();
				fixed = pending_fixed.pop_front();
				has_fixed = pending_has_fixed.pop_front();
				if (has_fixed && fixed != want) begin
					$display("%0t: table row %h disagrees with prediction %h", $time,
						fixed, want);
					failures++;
				end
				if (got.chg != want.chg) begin
					$display("%0t: charge_select expected %0d got %0d", $time, want.chg, got.chg);
					failures++;
				end
				if (got.dis != want.dis) begin
					$display("%0t: discharge_select expected %0d got %0d", $time,
						want.dis, got.dis);
					failures++;
				end
				if (got.meta != want.meta) begin
					$display("%0t: meta_state expected %0d got %0d", $time, want.meta, got.meta);
					failures++;
				end
				if (got.sub != want.sub) begin
					$display("%0t: charge_state expected %0d got %0d", $time, want.sub, got.sub);
					failures++;
				end
				if (got.deploy != want.deploy) begin
					$display("%0t: antenna_deploy_ok expected %0d got %0d", $time,
						want.deploy, got.deploy);
					failures++;
				end
				if (got.sane != want.sane) begin
					$display("%0t: above_sanity_mask expected %h got %h", $time,
						want.sane, got.sane);
					failures++;
				end
				if (got.retired != want.retired) begin
					$display("%0t: decommissioned_mask expected %h got %h", $time,
						want.retired, got.retired);
					failures++;
				end
			end
		end
	end

	// Watchdog over cycles in which neither side moves a beat and no register access is under way.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		tick_row_t rows [$];
		tick_row_t row;
		item_t     t;
		int        mode;
		reset_predictor();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: first row fixed from reset, then extremes and faults.
		row.tick = '{32'd0, 16'd3500, 16'd3600, 16'd3200, 16'd3100, 16'd3000,
			16'd3000, 1'b0, 1'b0, 16'd0, 4'd0};
		row.has_fixed = 1'b1;
		row.fixed = '{BAT_LI1, DIS_LI2, META_GOOD, SUB_NONE_FULL, 1'b0, 4'b0000, 4'b0000};
		rows.push_back(row);
		row.has_fixed = 1'b0;
		row.fixed = '0;
		row.tick = '{32'd10, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF,
			1'b1, 1'b1, 16'hFFFF, 4'd0};
		rows.push_back(row);
		row.tick = '{32'd20, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0,
			1'b1, 1'b0, 16'd2048, 4'd0};
		rows.push_back(row);
		row.tick = '{32'd30, 16'd4050, 16'd3900, 16'd3400, 16'd3400, 16'd3400,
			16'd3400, 1'b1, 1'b0, 16'd2048, 4'd0};
		rows.push_back(row);
		row.tick = '{32'd40, 16'd4050, 16'd4150, 16'd3400, 16'd3400, 16'd3400,
			16'd3400, 1'b1, 1'b0, 16'd2047, 4'd0};
		rows.push_back(row);
		row.tick = '{32'd50, 16'd4050, 16'd4050, 16'd3400, 16'd3300, 16'd3500,
			16'd3300, 1'b1, 1'b0, 16'd2048, 4'd0};
		rows.push_back(row);
		row.tick = '{32'd60, 16'd2000, 16'd2000, 16'd3400, 16'd3400, 16'd3400,
			16'd3400, 1'b1, 1'b1, 16'd0, 4'd0};
		rows.push_back(row);
		row.tick = '{32'd5000, 16'd2000, 16'd2000, 16'd3400, 16'd3400, 16'd3400,
			16'd3400, 1'b1, 1'b1, 16'd0, 4'd0};
		rows.push_back(row);
		row.tick = '{32'd5010, 16'd3900, 16'd3900, 16'd3400, 16'd3400, 16'd3400,
			16'd3400, 1'b1, 1'b1, 16'd0, 4'b0001};
		rows.push_back(row);
		row.tick = '{32'd5020, 16'd3900, 16'd3900, 16'd3400, 16'd3400, 16'd3400,
			16'd3400, 1'b0, 1'b1, 16'd0, 4'b1100};
		rows.push_back(row);
		row.tick = '{32'd5030, 16'd3900, 16'd3900, 16'd3400, 16'd3400, 16'd3400,
			16'd3400, 1'b1, 1'b1, 16'd0, 4'b0010};
		rows.push_back(row);
		row.tick = '{32'd5040, 16'd3900, 16'd4200, 16'd3400, 16'd3400, 16'd3400,
			16'd3400, 1'b1, 1'b1, 16'd0, 4'd0};
		rows.push_back(row);
		row.tick = '{32'd5050, 16'd3900, 16'd4200, 16'd3400, 16'd3400, 16'd3400,
			16'd3400, 1'b1, 1'b1, 16'd0, 4'd0};
		rows.push_back(row);
		row.tick = '{32'd200000, 16'd3900, 16'd3900, 16'd3400, 16'd3400, 16'd3400,
			16'd3400, 1'b1, 1'b1, 16'd0, 4'd0};
		rows.push_back(row);
		row.tick = '{32'hFFFF_FFFF, 16'd3900, 16'd3900, 16'd3700, 16'd3400, 16'd3700,
			16'd3400, 1'b1, 1'b0, 16'd4000, 4'hF};
		rows.push_back(row);
		row.tick = '{32'h0000_0100, 16'd3900, 16'd3900, 16'd3700, 16'd3400, 16'd3700,
			16'd3400, 1'b0, 1'b0, 16'd4000, 4'd0};
		rows.push_back(row);
		foreach (rows[i])
			send_tick(rows[i].tick, rows[i].has_fixed, rows[i].fixed);
		in_valid <= 1'b0;
		drain();

		// Every register at its extremes, with the not-full limit small and the low-voltage limit large.
		write_reg(REG_LI_FULL_SANITY, 32'd0);
		write_reg(REG_LI_FULL, 32'hFFFF);
		write_reg(REG_LF_FULL_MAX, 32'd0);
		write_reg(REG_LI_DOWN, 32'hFFFF);
		write_reg(REG_LI_LOW_POWER, 32'd0);
		write_reg(REG_LI_CRITICAL, 32'hFFFF);
		write_reg(REG_MAX_NO_FULL, 32'd0);
		write_reg(REG_MAX_LOW_VOLT, 32'hFFFF_FFFF);
		clock_now = 32'h0010_0000;
		for (int i = 0; i < 150; i++)
			send_tick(random_tick($urandom_range(0, 1)), 1'b0, '0);
		in_valid <= 1'b0;
		drain();

		write_reg(REG_LI_FULL_SANITY, 32'hFFFF);
		write_reg(REG_LI_FULL, 32'd0);
		write_reg(REG_LF_FULL_MAX, 32'hFFFF);
		write_reg(REG_LI_DOWN, 32'd0);
		write_reg(REG_LI_LOW_POWER, 32'hFFFF);
		write_reg(REG_LI_CRITICAL, 32'd0);
		write_reg(REG_MAX_NO_FULL, 32'hFFFF_FFFF);
		write_reg(REG_MAX_LOW_VOLT, 32'd0);
		for (int i = 0; i < 150; i++)
			send_tick(random_tick($urandom_range(0, 1)), 1'b0, '0);
		in_valid <= 1'b0;
		drain();

		// Realistic thresholds with tight timers so the sequences reach every mode.
		write_reg(REG_LI_FULL_SANITY, 32'd4000);
		write_reg(REG_LI_FULL, 32'd4100);
		write_reg(REG_LF_FULL_MAX, 32'd3600);
		write_reg(REG_LI_DOWN, 32'd3800);
		write_reg(REG_LI_LOW_POWER, 32'd3600);
		write_reg(REG_LI_CRITICAL, 32'd3000);
		write_reg(REG_MAX_NO_FULL, 32'd40000);
		write_reg(REG_MAX_LOW_VOLT, 32'd6000);
		for (int i = 0; i < NUM_RANDOM - 300; i++) begin
			mode = ($urandom_range(0, 9) == 0) ? 0 : 1;
			t = random_tick(mode);
			send_tick(t, 1'b0, '0);
			if (i == 300) begin
				in_valid <= 1'b0;
				while (pending_verdicts.size() != 0)
					@(posedge clk);
			end
		end
		in_valid <= 1'b0;
		drain();

		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
sv/bcs_pkg.sv
sv/bcs_cfg.sv
sv/bcs_core.sv
sv/battery_charge_scheduler_top.sv
sv/bcs_checker.sv
bench/battery_charge_scheduler_top_test.sv
